// File: design/sra_pkg.sv
// Shared types and constants for the slot ring allocator.
package sra_pkg;

   localparam int MAX_SLOTS      = 1024;
   localparam int MAX_SLOT_BYTES = 2048;

   localparam int COUNT_W  = 11;   // slot counts, 0..MAX_SLOTS
   localparam int INDEX_W  = 10;   // slot positions, 0..MAX_SLOTS-1
   localparam int BYTES_W  = 12;   // slot size, 0..MAX_SLOT_BYTES
   localparam int LEN_W    = 13;   // request length
   localparam int OFFSET_W = 21;   // byte offset of a slot
   localparam int CSR_W    = 12;   // widest register

   // register indexes
   typedef enum logic {
      CSR_SLOT_COUNT = 1'b0,
      CSR_SLOT_BYTES = 1'b1
   } csr_index_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   typedef enum logic {
      OP_STORE   = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [LEN_W-1:0]     item_length;
      logic [COUNT_W-1:0]   release_count;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   slot_index;
      logic [OFFSET_W-1:0]  byte_offset;
      logic [COUNT_W-1:0]   free_after;
      logic [INDEX_W-1:0]   read_position;
   } rsp_type;

endpackage

// File: design/sra_req_if.sv
// Request channel interface of the slot ring allocator.
interface sra_req_if;
   import sra_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/sra_rsp_if.sv
// Response channel interface of the slot ring allocator.
interface sra_rsp_if;
   import sra_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/slot_ring_allocator_core.sv
// Slot ring allocator: free count and ring pointers for fixed-size slots.
//
// Usage:
//   req_chan  - one request per valid/ready handshake: store (asks for one slot
//               for item_length bytes) or release (frees release_count slots).
//   rsp_chan  - exactly one response per request, in request order: status,
//               slot index and byte offset of a stored item, free count and
//               read slot after the request.
//   csr_*     - write-only registers: slot_count (index 0, also restarts the
//               ring) and slot_bytes (index 1). Write only while idle.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken; ring state is updated at acceptance, so
//   back-to-back requests see each other's effect with no bubble.
// The response register is the only stage: while the receiver stalls it holds
//   its response and req_chan.ready stays low until it is taken.
// Reset: slot_count 1024, slot_bytes 2048, all slots free, pointers at 0,
//   no response pending.
module slot_ring_allocator_core (
   input  logic                    clock,
   input  logic                    reset,
   sra_req_if.sink                 req_chan,
   sra_rsp_if.source               rsp_chan,
   input  logic                    csr_we,
   input  sra_pkg::csr_index_type  csr_index,
   input  logic [sra_pkg::CSR_W-1:0] csr_wdata
);
   import sra_pkg::*;

   // configuration
   logic [COUNT_W-1:0]  slot_count_ff, slot_count_in;
   logic [BYTES_W-1:0]  slot_bytes_ff, slot_bytes_in;

   // ring state
   logic [COUNT_W-1:0]  free_ff, free_in;
   logic [INDEX_W-1:0]  write_slot_ff, write_slot_in;
   logic [INDEX_W-1:0]  read_slot_ff, read_slot_in;

   // response stage
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic [COUNT_W-1:0]  cfg_count;
   logic [BYTES_W-1:0]  cfg_bytes;

   logic [COUNT_W-1:0]  rel_cnt;
   logic [COUNT_W:0]    free_sum;
   logic [COUNT_W-1:0]  free_rel;
   logic [COUNT_W:0]    read_sum;
   logic [COUNT_W:0]    read_wrap;
   logic [COUNT_W-1:0]  write_inc;
   logic [INDEX_W-1:0]  write_next;
   logic [INDEX_W+BYTES_W-1:0] offset_full;
   logic                too_long;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // register write clamping: zero count reads as one, both saturate at max
   always_comb begin
      cfg_count = csr_wdata[COUNT_W-1:0];
      if (cfg_count == '0) begin
         cfg_count = COUNT_W'(1);
      end else if (cfg_count > COUNT_W'(MAX_SLOTS)) begin
         cfg_count = COUNT_W'(MAX_SLOTS);
      end
      cfg_bytes = csr_wdata[BYTES_W-1:0];
      if (cfg_bytes > BYTES_W'(MAX_SLOT_BYTES)) begin
         cfg_bytes = BYTES_W'(MAX_SLOT_BYTES);
      end
   end

   // release path: clamp, saturate free count, wrap read slot with one subtract
   always_comb begin
      rel_cnt   = (req_chan.payload.release_count > slot_count_ff) ?
                  slot_count_ff : req_chan.payload.release_count;
      free_sum  = {1'b0, free_ff} + {1'b0, rel_cnt};
      free_rel  = (free_sum > {1'b0, slot_count_ff}) ?
                  slot_count_ff : free_sum[COUNT_W-1:0];
      read_sum  = {2'b00, read_slot_ff} + {1'b0, rel_cnt};
      read_wrap = (read_sum >= {1'b0, slot_count_ff}) ?
                  (read_sum - {1'b0, slot_count_ff}) : read_sum;
   end

   // store path
   always_comb begin
      write_inc   = {1'b0, write_slot_ff} + COUNT_W'(1);
      write_next  = (write_inc >= slot_count_ff) ? '0 : write_inc[INDEX_W-1:0];
      offset_full = write_slot_ff * slot_bytes_ff;
      too_long    = req_chan.payload.item_length > {1'b0, slot_bytes_ff};
   end

   always_comb begin
      slot_count_in = slot_count_ff;
      slot_bytes_in = slot_bytes_ff;
      free_in       = free_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = ST_OK;
         rsp_data_in.slot_index  = '0;
         rsp_data_in.byte_offset = '0;
         unique case (req_chan.payload.opcode)
            OP_STORE: begin
               priority if (free_ff == '0) begin
                  rsp_data_in.status = ST_NO_SPACE;
               end else if (too_long) begin
                  rsp_data_in.status = ST_TOO_LONG;
               end else begin
                  rsp_data_in.slot_index  = write_slot_ff;
                  rsp_data_in.byte_offset = offset_full[OFFSET_W-1:0];
                  free_in       = free_ff - COUNT_W'(1);
                  write_slot_in = write_next;
               end
            end
            OP_RELEASE: begin
               free_in      = free_rel;
               read_slot_in = read_wrap[INDEX_W-1:0];
            end
            default: begin
               rsp_data_in.status = ST_OK;
            end
         endcase
         rsp_data_in.free_after    = free_in;
         rsp_data_in.read_position = read_slot_in;
      end

      // register writes are to be made only while idle; the block itself does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_COUNT: begin
               slot_count_in = cfg_count;
               free_in       = cfg_count;
               write_slot_in = '0;
               read_slot_in  = '0;
            end
            CSR_SLOT_BYTES: begin
               slot_bytes_in = cfg_bytes;
            end
            default: begin
               slot_bytes_in = slot_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_W'(MAX_SLOTS);
         slot_bytes_ff <= BYTES_W'(MAX_SLOT_BYTES);
         free_ff       <= COUNT_W'(MAX_SLOTS);
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         slot_bytes_ff <= slot_bytes_in;
         free_ff       <= free_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/sra_checker.sv
// Port-level checks for the slot ring allocator, bound to the top level.
module sra_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sra_pkg::rsp_type     rsp_payload
);
   import sra_pkg::*;

   // no response right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // every accepted request shows a response next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // failed stores carry no slot
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |->
         rsp_payload.slot_index == '0 && rsp_payload.byte_offset == '0)
      else $error("failed store returned a slot");

   // no-space only when the ring is full
   a_no_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_NO_SPACE |-> rsp_payload.free_after == '0)
      else $error("no-space reported with free slots");

endmodule

bind slot_ring_allocator_core sra_checker u_sra_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the slot ring allocator: directed and random requests.
module tb;
   import sra_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 4;       // response register is one stage deep

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   sra_req_if req_chan ();
   sra_rsp_if rsp_chan ();

   slot_ring_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the ring bookkeeping, advanced at every accepted request.
   int unsigned ring_slots;
   int unsigned ring_slot_bytes;
   int unsigned ring_free;
   int unsigned ring_wr;
   int unsigned ring_rd;

   req_type     pending_reqs[$];   // requests not yet driven
   rsp_type     slot_replies[$];   // predicted responses, oldest first
   rsp_type     oldest_reply;

   int unsigned reqs_queued;
   int unsigned replies_seen;
   int unsigned mismatches;
   int unsigned cycle_count;

   // Handshakes seen at the last rising edge, used by the drivers at the falling edge.
   logic        req_fire;
   logic        rsp_fire;

   // Per-phase switches: when set, that side never idles.
   bit          req_calm;
   bit          rsp_calm;
   int unsigned req_gap;
   int unsigned rsp_wait;

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Ring predictor
   // ---------------------------------------------------------------------

   function automatic void ring_restart();
      ring_free = ring_slots;
      ring_wr   = 0;
      ring_rd   = 0;
   endfunction

   function automatic void ring_reset();
      ring_slots      = MAX_SLOTS;
      ring_slot_bytes = MAX_SLOT_BYTES;
      ring_restart();
   endfunction

   function automatic void ring_configure(csr_index_type idx, logic [CSR_W-1:0] value);
      int unsigned v;
      case (idx)
         CSR_SLOT_COUNT: begin
            // only the low 11 bits count; zero means one slot
            v = value[COUNT_W-1:0];
            if (v == 0) v = 1;
            if (v > MAX_SLOTS) v = MAX_SLOTS;
            ring_slots = v;
            ring_restart();
         end
         CSR_SLOT_BYTES: begin
            v = value;
            if (v > MAX_SLOT_BYTES) v = MAX_SLOT_BYTES;
            ring_slot_bytes = v;
         end
         default: ;
      endcase
   endfunction

   // Apply one request to the mirror and return the response it must produce.
   function automatic rsp_type ring_outcome(req_type rq);
      rsp_type     r;
      int unsigned freed;
      r        = '0;
      r.status = ST_OK;
      if (rq.opcode == OP_STORE) begin
         // a full ring wins over an oversize request
         if (ring_free == 0) begin
            r.status = ST_NO_SPACE;
         end else if (rq.item_length > ring_slot_bytes) begin
            r.status = ST_TOO_LONG;
         end else begin
            r.slot_index  = INDEX_W'(ring_wr);
            r.byte_offset = OFFSET_W'(ring_wr * ring_slot_bytes);
            ring_free--;
            ring_wr++;
            if (ring_wr >= ring_slots) ring_wr = 0;
         end
      end else begin
         freed = rq.release_count;
         if (freed > ring_slots) freed = ring_slots;
         ring_free += freed;
         if (ring_free > ring_slots) ring_free = ring_slots;
         ring_rd += freed;
         if (ring_rd >= ring_slots) ring_rd -= ring_slots;
      end
      r.free_after    = COUNT_W'(ring_free);
      r.read_position = INDEX_W'(ring_rd);
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: predicts on request acceptance, checks on response acceptance
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      req_fire    <= req_chan.valid && req_chan.ready;
      rsp_fire    <= rsp_chan.valid && rsp_chan.ready;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stalled, %0d requests queued, %0d responses checked",
                  $time, reqs_queued, replies_seen);
         $display("TB_ERROR");
         $finish;
      end else if (reset) begin
         ring_reset();
         slot_replies.delete();
      end else begin
         if (csr_we) ring_configure(csr_index, csr_wdata);
         // request first, so a same-edge response would still find its prediction
         if (req_chan.valid && req_chan.ready)
            slot_replies.push_back(ring_outcome(req_chan.payload));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (slot_replies.size() == 0) begin
               $display("%0t: response with nothing outstanding, expected none actual %h",
                        $time, rsp_chan.payload);
               mismatches++;
            end else begin
               oldest_reply = slot_replies.pop_front();
               replies_seen++;
               check_field("status", oldest_reply.status, rsp_chan.payload.status);
               check_field("slot_index", oldest_reply.slot_index,
                           rsp_chan.payload.slot_index);
               check_field("byte_offset", oldest_reply.byte_offset,
                           rsp_chan.payload.byte_offset);
               check_field("free_after", oldest_reply.free_after,
                           rsp_chan.payload.free_after);
               check_field("read_position", oldest_reply.read_position,
                           rsp_chan.payload.read_position);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: change inputs at the falling edge
   // ---------------------------------------------------------------------

   function automatic int unsigned draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   // Request side: hold the current request until taken, then idle for the drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = draw_wait(req_calm);
      end else if (!req_chan.valid || req_fire) begin
         if (req_gap != 0 || pending_reqs.size() == 0) begin
            req_chan.valid <= 1'b0;
            if (req_gap != 0) req_gap--;
         end else begin
            req_chan.valid   <= 1'b1;
            req_chan.payload <= pending_reqs.pop_front();
            req_gap = draw_wait(req_calm);
         end
      end
   end

   // Response side: after each taken response, stall the next one for a drawn count.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = draw_wait(rsp_calm);
      end else begin
         if (rsp_fire) rsp_wait = draw_wait(rsp_calm);
         if (rsp_wait != 0) begin
            rsp_chan.ready <= 1'b0;
            if (rsp_chan.valid) rsp_wait--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic queue_request(opcode_type op, int unsigned len, int unsigned cnt);
      req_type rq;
      rq.opcode        = op;
      rq.item_length   = LEN_W'(len);
      rq.release_count = COUNT_W'(cnt);
      pending_reqs.push_back(rq);
      reqs_queued++;
   endtask

   // Mostly legal lengths and small releases so the ring fills, wraps and runs dry;
   // the rest straddles the slot size or is raw noise over the full field width.
   function automatic req_type random_request(int unsigned store_pct);
      req_type     rq;
      int unsigned pick;
      rq.item_length   = LEN_W'($urandom);
      rq.release_count = COUNT_W'($urandom);
      pick = $urandom_range(0, 9);
      if ($urandom_range(1, 100) <= store_pct) begin
         rq.opcode = OP_STORE;
         if (pick < 7)
            rq.item_length = LEN_W'($urandom_range(0, ring_slot_bytes));
         else if (pick < 9)
            rq.item_length = LEN_W'($urandom_range(ring_slot_bytes, ring_slot_bytes + 64));
      end else begin
         rq.opcode = OP_RELEASE;
         if (pick < 7)
            rq.release_count = COUNT_W'($urandom_range(0, 3));
         else if (pick < 9)
            rq.release_count = COUNT_W'($urandom_range(0, ring_slots));
      end
      return rq;
   endfunction

   task automatic queue_random(int unsigned n, int unsigned store_pct);
      repeat (n) begin
         pending_reqs.push_back(random_request(store_pct));
         reqs_queued++;
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Every request gets exactly one response, so idle means all answered.
   task automatic wait_idle();
      while (replies_seen != reqs_queued) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned new_slots;
      int unsigned new_bytes;

      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_SLOT_COUNT;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      req_fire         = 1'b0;
      rsp_fire         = 1'b0;
      req_calm         = 1'b0;
      rsp_calm         = 1'b0;
      req_gap          = 0;
      rsp_wait         = 0;
      reqs_queued      = 0;
      replies_seen     = 0;
      mismatches       = 0;
      cycle_count      = 0;
      ring_reset();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset sizes: field extremes, oversize lengths, release clamping and wrap.
      queue_request(OP_STORE,   0,    0);
      queue_request(OP_STORE,   2048, 2047);
      queue_request(OP_STORE,   2049, 0);     // one byte over the slot
      queue_request(OP_STORE,   8191, 0);     // all length bits set
      queue_request(OP_STORE,   4096, 0);
      queue_request(OP_RELEASE, 0,    0);
      queue_request(OP_RELEASE, 0,    2047);  // clamps to slot count, read slot wraps to 0
      queue_request(OP_RELEASE, 0,    1);
      queue_request(OP_STORE,   5,    2047);
      queue_request(OP_RELEASE, 8191, 1023);  // lands exactly on the wrap point
      wait_idle();

      // Single one-byte slot: full ring, no-space before too-long.
      write_csr(CSR_SLOT_COUNT, CSR_W'(1));
      write_csr(CSR_SLOT_BYTES, CSR_W'(1));
      queue_request(OP_STORE,   1,    0);
      queue_request(OP_STORE,   1,    0);     // no free slot
      queue_request(OP_STORE,   2,    0);     // no free slot wins over too long
      queue_request(OP_RELEASE, 0,    0);
      queue_request(OP_RELEASE, 0,    1);
      queue_request(OP_STORE,   2,    0);     // too long
      queue_request(OP_STORE,   0,    0);
      queue_request(OP_RELEASE, 0,    2047);
      wait_idle();

      // Zero slot count reads as one; zero slot size refuses anything nonempty.
      write_csr(CSR_SLOT_COUNT, '0);
      write_csr(CSR_SLOT_BYTES, '0);
      queue_request(OP_STORE,   0,    0);
      queue_request(OP_RELEASE, 0,    5);
      queue_request(OP_STORE,   1,    0);
      wait_idle();

      // Bit 11 alone masks to zero slots (one); slot size all ones saturates.
      write_csr(CSR_SLOT_COUNT, 12'h800);
      write_csr(CSR_SLOT_BYTES, 12'hFFF);
      queue_request(OP_STORE,   2048, 0);
      queue_request(OP_STORE,   0,    0);     // no free slot
      wait_idle();

      // Long store run on the full ring so the write slot and offset climb high.
      write_csr(CSR_SLOT_COUNT, 12'hFFF);     // saturates to the maximum
      write_csr(CSR_SLOT_BYTES, 12'h800);
      req_calm = 1'b1;
      rsp_calm = 1'b0;
      queue_random(600, 95);
      wait_idle();

      // Random sizes; the slot count is sometimes left alone so the ring carries over.
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 4))
            0:       new_slots = $urandom_range(1, 4);
            1:       new_slots = $urandom_range(1, 16);
            2:       new_slots = $urandom_range(1, MAX_SLOTS);
            3:       new_slots = MAX_SLOTS;
            default: new_slots = $urandom_range(0, 4095);
         endcase
         case ($urandom_range(0, 3))
            0:       new_bytes = 1;
            1:       new_bytes = $urandom_range(0, 64);
            2:       new_bytes = MAX_SLOT_BYTES;
            default: new_bytes = $urandom_range(0, 4095);
         endcase
         if (ph == 0 || $urandom_range(0, 2) != 0)
            write_csr(CSR_SLOT_COUNT, CSR_W'(new_slots));
         write_csr(CSR_SLOT_BYTES, CSR_W'(new_bytes));
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         queue_random(60, $urandom_range(40, 85));
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
